[rtl/c2pavg_pkg.sv]
package c2pavg_pkg;

   // Widths of the fixed channel fields.
   localparam int CELL_W     = 32;
   localparam int PX_W       = 7;
   localparam int PY_W       = 7;
   localparam int PZ_W       = 12;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - CELL_W - PX_W - PY_W - PZ_W;

   // Widths of the size registers and of the write port.
   localparam int SX_W       = 8;
   localparam int SY_W       = 8;
   localparam int SZ_W       = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   // Largest number of grid points along z.
   localparam int LIMIT_Z    = 4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X = 2'd0,
      CSR_SIZE_Y = 2'd1,
      CSR_SIZE_Z = 2'd2
   } csr_index_type;

endpackage

[rtl/cell_to_point_average_3d.sv]
// Cell-to-point averaging over a structured 3D grid.
// Cell values enter on the req channel in raster order (x fastest, then y, then z), one
// cell per transaction. Each grid point leaves on the rsp channel as the floor mean of the
// up to eight cells around it, tagged with its coordinates. A cell sends every point whose
// last contributing cell it is: one point inside the grid, up to eight on the far edges.
// rsp_tlast marks the last point of a cell and rsp_tuser the last point of the volume.
// The csr port sets the grid size in points; any write to a size register restarts the volume at the origin.
// The first point of a cell reaches rsp through stage 1, stage 2, stage 3, the emission stage and the output register.
// Throughput: one cell per cycle while the receiver keeps up. A cell that sends several
// points holds the emission stage until its last point is emitted, so req_tready can drop
// behind it; the single emission stage ahead of the output register sets this limit.
// The current and previous z planes of cells live in a plane memory with two read ports,
// and the previous plane's previous row in a row memory; all neighbor values come from
// those reads and from the registers of the cell just before.
// Reset clears the position, sets all sizes to 2 and empties the pipeline. The memories
// get no clearing pass; only entries written in the current volume are ever used.
// When the receiver stalls, the output register holds its point and the pipeline fills,
// after which req_tready stays low until the receiver takes results again.
module cell_to_point_average_3d #(
   parameter int MAX_X      = 128,
   parameter int MAX_Y      = 128,
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [c2pavg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [c2pavg_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata, from bit 0: cell_value[31:0]
   input  logic [c2pavg_pkg::CELL_W-1:0]        req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata, from bit 0: point_value[31:0], point_x[6:0], point_y[6:0],
   // point_z[11:0], zero padding
   output logic [c2pavg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                 rsp_tlast,
   // rsp_tuser, from bit 0: volume_done
   output logic                                 rsp_tuser
);

   localparam int W     = VALUE_BITS;
   localparam int XW    = $clog2(MAX_X);
   localparam int YW    = $clog2(MAX_Y);
   localparam int ZW    = c2pavg_pkg::PZ_W;
   localparam int DEPTH = MAX_X * MAX_Y;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = c2pavg_pkg::CELL_W;
   localparam int PXW   = c2pavg_pkg::PX_W;
   localparam int PYW   = c2pavg_pkg::PY_W;
   localparam int PZW   = c2pavg_pkg::PZ_W;

   // Cell position and far-edge flags that travel with a cell down the pipeline.
   typedef struct packed {
      logic [XW-1:0] cx;
      logic [YW-1:0] cy;
      logic [ZW-1:0] cz;
      logic          ex;
      logic          ey;
      logic          ez;
   } pos_type;

   // Size registers, held as the index of the last cell along each axis.
   logic [XW-1:0] last_x_ff, last_x_in;
   logic [YW-1:0] last_y_ff, last_y_in;
   logic [ZW-1:0] last_z_ff, last_z_in;

   // Position of the next cell and the plane memory address of its row.
   logic [XW-1:0] cx_ff, cx_in;
   logic [YW-1:0] cy_ff, cy_in;
   logic [ZW-1:0] cz_ff, cz_in;
   logic [AW-1:0] row_base_ff, row_base_in;

   logic                                    accept;
   logic [W-1:0]                            cell_w;
   logic [AW-1:0]                           addr_cur;
   logic [AW-1:0]                           addr_prev;
   logic [c2pavg_pkg::SX_W-1:0]             wr_sx;
   logic [c2pavg_pkg::SY_W-1:0]             wr_sy;
   logic [c2pavg_pkg::SZ_W-1:0]             wr_sz;
   logic                                    cfg_hit;
   pos_type                                 pos_now;

   // Memories.
   logic [W-1:0] plane_mem [DEPTH];
   logic [W-1:0] row_mem   [MAX_X];

   // Stage 1: the cell and its memory reads.
   logic          s1_v_ff, s1_v_in;
   pos_type       s1_pos_ff;
   logic [W-1:0]  s1_val_ff;
   logic [W-1:0]  rd_pz_ff;
   logic [W-1:0]  rd_py_ff;
   logic [W-1:0]  row_rd_ff;
   logic          fwd_ff;
   logic [W-1:0]  fwd_val_ff;
   logic [W-1:0]  prev_ff [2][2];
   logic [W-1:0]  cur_c   [2][2];

   // Stage 2: sums along x, indexed [x offset][z][y].
   logic                 s2_v_ff, s2_v_in;
   pos_type              s2_pos_ff;
   logic signed [W:0]    xs_ff [2][2][2];
   logic signed [W:0]    xs_in [2][2][2];

   // Stage 3: sums along x and y, indexed [x offset][y offset][z].
   logic                 s3_v_ff, s3_v_in;
   pos_type              s3_pos_ff;
   logic signed [W+1:0]  ys_ff [2][2][2];
   logic signed [W+1:0]  ys_in [2][2][2];

   // Emission stage: the eight point means of a cell, indexed {dz, dy, dx}.
   logic          se_v_ff, se_v_in;
   pos_type       se_pos_ff;
   logic [W-1:0]  se_avg_ff [8];
   logic [W-1:0]  avg_in    [8];
   logic          se_dx_ff, se_dx_in;
   logic          se_dy_ff, se_dy_in;
   logic          se_dz_ff, se_dz_in;
   logic          se_last;

   // Output register.
   logic            rsp_v_ff, rsp_v_in;
   logic [W-1:0]    rsp_val_ff;
   logic [PXW-1:0]  rsp_x_ff;
   logic [PYW-1:0]  rsp_y_ff;
   logic [PZW-1:0]  rsp_z_ff;
   logic            rsp_last_ff;
   logic            rsp_done_ff;

   // Pipeline flow control.
   logic out_load, emit, se_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;

   assign out_load = !rsp_v_ff || rsp_tready;
   assign emit     = se_v_ff && out_load;
   assign se_free  = !se_v_ff || (emit && se_last);
   assign s3_adv   = s3_v_ff && se_free;
   assign s3_free  = !s3_v_ff || se_free;
   assign s2_adv   = s2_v_ff && s3_free;
   assign s2_free  = !s2_v_ff || s3_free;
   assign s1_adv   = s1_v_ff && s2_free;
   assign s1_free  = !s1_v_ff || s2_free;

   assign req_tready = s1_free;
   assign accept     = req_tvalid && req_tready;
   assign cell_w     = W'(req_tdata);

   assign addr_cur  = row_base_ff + AW'(cx_ff);
   assign addr_prev = row_base_ff - AW'(MAX_X) + AW'(cx_ff);

   assign pos_now.cx = cx_ff;
   assign pos_now.cy = cy_ff;
   assign pos_now.cz = cz_ff;
   assign pos_now.ex = (cx_ff == last_x_ff);
   assign pos_now.ey = (cy_ff == last_y_ff);
   assign pos_now.ez = (cz_ff == last_z_ff);

   // Size registers are clamped to the supported range when written.
   assign wr_sx = csr_wdata[c2pavg_pkg::SX_W-1:0];
   assign wr_sy = csr_wdata[c2pavg_pkg::SY_W-1:0];
   assign wr_sz = csr_wdata[c2pavg_pkg::SZ_W-1:0];

   always_comb begin
      cfg_hit   = 1'b0;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      last_z_in = last_z_ff;
      if (csr_we) begin
         unique case (c2pavg_pkg::csr_index_type'(csr_index))
            c2pavg_pkg::CSR_SIZE_X: begin
               cfg_hit   = 1'b1;
               last_x_in = (int'(wr_sx) < 2) ? '0 :
                           (int'(wr_sx) > MAX_X) ? XW'(MAX_X - 2) : XW'(int'(wr_sx) - 2);
            end
            c2pavg_pkg::CSR_SIZE_Y: begin
               cfg_hit   = 1'b1;
               last_y_in = (int'(wr_sy) < 2) ? '0 :
                           (int'(wr_sy) > MAX_Y) ? YW'(MAX_Y - 2) : YW'(int'(wr_sy) - 2);
            end
            c2pavg_pkg::CSR_SIZE_Z: begin
               cfg_hit   = 1'b1;
               last_z_in = (int'(wr_sz) < 2) ? '0 :
                           (int'(wr_sz) > c2pavg_pkg::LIMIT_Z) ?
                           ZW'(c2pavg_pkg::LIMIT_Z - 2) : ZW'(int'(wr_sz) - 2);
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   // Raster position of the next cell; a size write restarts the volume.
   always_comb begin
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cz_in       = cz_ff;
      row_base_in = row_base_ff;
      if (cfg_hit) begin
         cx_in       = '0;
         cy_in       = '0;
         cz_in       = '0;
         row_base_in = '0;
      end else if (accept) begin
         if (!pos_now.ex) begin
            cx_in = cx_ff + XW'(1);
         end else begin
            cx_in = '0;
            if (!pos_now.ey) begin
               cy_in       = cy_ff + YW'(1);
               row_base_in = row_base_ff + AW'(MAX_X);
            end else begin
               cy_in       = '0;
               row_base_in = '0;
               cz_in       = pos_now.ez ? '0 : cz_ff + ZW'(1);
            end
         end
      end
   end

   // Plane memory: read-before-write at the cell's own slot gives the cell one plane
   // down; the second port gives the cell one row back in the current plane.
   always_ff @(posedge clock) begin
      if (accept) begin
         plane_mem[addr_cur] <= cell_w;
         rd_pz_ff            <= plane_mem[addr_cur];
         rd_py_ff            <= plane_mem[addr_prev];
      end
   end

   // Row memory keeps the previous plane's cells of the previous row.
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         row_mem[s1_pos_ff.cx] <= rd_pz_ff;
      end
      if (accept) begin
         row_rd_ff <= row_mem[cx_ff];
      end
   end

   // Stage 1 payload. With a one-cell row, the row memory entry being written at the same
   // edge is the one read, so its new value is forwarded.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff  <= pos_now;
         s1_val_ff  <= cell_w;
         fwd_ff     <= s1_adv && (s1_pos_ff.cx == cx_ff);
         fwd_val_ff <= rd_pz_ff;
      end
      if (s1_adv) begin
         prev_ff <= cur_c;
      end
   end

   // Sums along x: offset 0 is the point at the cell, offset 1 the point past the far edge.
   always_comb begin
      cur_c[1][1] = s1_val_ff;
      cur_c[1][0] = rd_py_ff;
      cur_c[0][1] = rd_pz_ff;
      cur_c[0][0] = fwd_ff ? fwd_val_ff : row_rd_ff;
      for (int z = 0; z < 2; z++) begin
         for (int y = 0; y < 2; y++) begin
            xs_in[1][z][y] = (W+1)'($signed(cur_c[z][y]));
            xs_in[0][z][y] = (W+1)'($signed(cur_c[z][y])) +
                             ((s1_pos_ff.cx != '0) ? (W+1)'($signed(prev_ff[z][y])) : '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_pos_ff <= s1_pos_ff;
         xs_ff     <= xs_in;
      end
   end

   // Sums along y.
   always_comb begin
      for (int dx = 0; dx < 2; dx++) begin
         for (int z = 0; z < 2; z++) begin
            ys_in[dx][1][z] = (W+2)'(xs_ff[dx][z][1]);
            ys_in[dx][0][z] = (W+2)'(xs_ff[dx][z][1]) +
                              ((s2_pos_ff.cy != '0) ? (W+2)'(xs_ff[dx][z][0]) : '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s3_pos_ff <= s2_pos_ff;
         ys_ff     <= ys_in;
      end
   end

   // Sums along z and the floor division by the number of contributing cells.
   always_comb begin
      logic signed [W+2:0] zs;
      logic [1:0]          sh;
      logic                bx;
      logic                by;
      logic                bz;
      for (int i = 0; i < 8; i++) begin
         bx = 1'(i);
         by = 1'(i >> 1);
         bz = 1'(i >> 2);
         zs = (W+3)'(ys_ff[bx][by][1]) +
              ((!bz && (s3_pos_ff.cz != '0)) ? (W+3)'(ys_ff[bx][by][0]) : '0);
         sh = 2'(!bx && (s3_pos_ff.cx != '0)) + 2'(!by && (s3_pos_ff.cy != '0)) +
              2'(!bz && (s3_pos_ff.cz != '0));
         avg_in[i] = W'(zs >>> sh);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         se_pos_ff <= s3_pos_ff;
         se_avg_ff <= avg_in;
      end
   end

   // Emission walks the points of the cell in z, y, x order, x fastest.
   assign se_last = (se_dx_ff == se_pos_ff.ex) && (se_dy_ff == se_pos_ff.ey) &&
                    (se_dz_ff == se_pos_ff.ez);

   always_comb begin
      se_dx_in = se_dx_ff;
      se_dy_in = se_dy_ff;
      se_dz_in = se_dz_ff;
      if (s3_adv) begin
         se_dx_in = 1'b0;
         se_dy_in = 1'b0;
         se_dz_in = 1'b0;
      end else if (emit && !se_last) begin
         if (se_dx_ff != se_pos_ff.ex) begin
            se_dx_in = 1'b1;
         end else begin
            se_dx_in = 1'b0;
            if (se_dy_ff != se_pos_ff.ey) begin
               se_dy_in = 1'b1;
            end else begin
               se_dy_in = 1'b0;
               se_dz_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_val_ff  <= se_avg_ff[{se_dz_ff, se_dy_ff, se_dx_ff}];
         rsp_x_ff    <= PXW'(32'(se_pos_ff.cx) + 32'(se_dx_ff));
         rsp_y_ff    <= PYW'(32'(se_pos_ff.cy) + 32'(se_dy_ff));
         rsp_z_ff    <= PZW'(32'(se_pos_ff.cz) + 32'(se_dz_ff));
         rsp_last_ff <= se_last;
         rsp_done_ff <= se_last && se_pos_ff.ex && se_pos_ff.ey && se_pos_ff.ez;
      end
   end

   // Stage occupancy.
   always_comb begin
      s1_v_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);
      s2_v_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_ff);
      s3_v_in  = s2_adv ? 1'b1 : (s3_adv ? 1'b0 : s3_v_ff);
      se_v_in  = s3_adv ? 1'b1 : ((emit && se_last) ? 1'b0 : se_v_ff);
      rsp_v_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff   <= '0;
         last_y_ff   <= '0;
         last_z_ff   <= '0;
         cx_ff       <= '0;
         cy_ff       <= '0;
         cz_ff       <= '0;
         row_base_ff <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         se_v_ff     <= 1'b0;
         se_dx_ff    <= 1'b0;
         se_dy_ff    <= 1'b0;
         se_dz_ff    <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         last_x_ff   <= last_x_in;
         last_y_ff   <= last_y_in;
         last_z_ff   <= last_z_in;
         cx_ff       <= cx_in;
         cy_ff       <= cy_in;
         cz_ff       <= cz_in;
         row_base_ff <= row_base_in;
         s1_v_ff     <= s1_v_in;
         s2_v_ff     <= s2_v_in;
         s3_v_ff     <= s3_v_in;
         se_v_ff     <= se_v_in;
         se_dx_ff    <= se_dx_in;
         se_dy_ff    <= se_dy_in;
         se_dz_ff    <= se_dz_in;
         rsp_v_ff    <= rsp_v_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{c2pavg_pkg::RSP_PAD_W{1'b0}}, rsp_z_ff, rsp_y_ff, rsp_x_ff,
                        CW'(rsp_val_ff)};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   // The block is built with its default sizes, and the predictor uses the same ones.
   localparam int MAX_X       = 128;
   localparam int MAX_Y       = 128;
   localparam int VALUE_BITS  = 32;
   localparam int STORE_DEPTH = MAX_X * MAX_Y;

   // Channel and register widths shared with the block.
   localparam int CSR_IDX_W  = c2pavg_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = c2pavg_pkg::CSR_DATA_W;
   localparam int CELL_W     = c2pavg_pkg::CELL_W;
   localparam int PX_W       = c2pavg_pkg::PX_W;
   localparam int PY_W       = c2pavg_pkg::PY_W;
   localparam int PZ_W       = c2pavg_pkg::PZ_W;
   localparam int RSP_DATA_W = c2pavg_pkg::RSP_DATA_W;
   localparam int RSP_PAD_W  = c2pavg_pkg::RSP_PAD_W;
   localparam int SX_W       = c2pavg_pkg::SX_W;
   localparam int SY_W       = c2pavg_pkg::SY_W;
   localparam int SZ_W       = c2pavg_pkg::SZ_W;
   localparam int LIMIT_Z    = c2pavg_pkg::LIMIT_Z;

   // A long receiver hold-off lets the pipeline fill and stall the input side.
   localparam int HOLD_CYCLES      = 300;
   // Cycles without any transaction before the run is declared hung.
   localparam int WATCHDOG_LIMIT   = 5000;
   // Settling time after the last expected point.
   localparam int DRAIN_CYCLES     = 20;
   localparam int MISMATCH_REPORTS = 10;
   // Per-phase count of random cells, not counting the back-pressure volume.
   localparam int PHASE_CELLS      = 35;

   // Register index that maps to no size register; a write there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam logic [CELL_W-1:0] CELL_MAX = 32'h7FFF_FFFF;
   localparam logic [CELL_W-1:0] CELL_MIN = 32'h8000_0000;

   // One averaged grid point as it appears on the result channel.
   typedef struct packed {
      logic [CELL_W-1:0] value;
      logic [PX_W-1:0]   x;
      logic [PY_W-1:0]   y;
      logic [PZ_W-1:0]   z;
      logic              run_last;
      logic              volume_done;
   } grid_point_type;

   // All block inputs hold known values from time zero.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = c2pavg_pkg::CSR_SIZE_X;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CELL_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   // Cells waiting to be offered, and points the block still owes us.
   logic [CELL_W-1:0] cell_queue [$];
   grid_point_type    pending_points [$];

   // Shadow copy of the block's state: the plane window, its write slot,
   // the position of the next cell and the three size registers.
   int                cell_store [STORE_DEPTH];
   int                store_slot = 0;
   int                cell_x = 0;
   int                cell_y = 0;
   int                cell_z = 0;
   logic [SX_W-1:0]   size_x_reg = 8'd2;
   logic [SY_W-1:0]   size_y_reg = 8'd2;
   logic [SZ_W-1:0]   size_z_reg = 13'd2;

   // Idle percentages per side, set by the sequence and used by the two handshake blocks.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // The sequence asks for a hold-off by bumping hold_requests; the receiver serves it.
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   int mismatch_count = 0;
   int quiet_cycles   = 0;

   cell_to_point_average_3d #(
      .MAX_X      (MAX_X),
      .MAX_Y      (MAX_Y),
      .VALUE_BITS (VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int clamp_size(input int v, input int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
   endfunction

   // Cell values lean toward the extremes and small numbers around zero, so that
   // sums carry into the upper bits and negative means exercise the floor rounding.
   function automatic logic [CELL_W-1:0] random_cell();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return CELL_MAX;
         1: return CELL_MIN;
         2: return 32'(int'($urandom_range(0, 32)) - 16);
         3: return CELL_MAX - 32'($urandom_range(0, 7));
         4: return CELL_MIN + 32'($urandom_range(0, 7));
         default: return $urandom();
      endcase
   endfunction

   // Appends one cell to the tail of the send queue.
   task automatic queue_cell(input logic [CELL_W-1:0] c);
      cell_queue.insert(cell_queue.size(), c);
   endtask

   // Takes one accepted cell, stores it in the plane window and queues every
   // grid point for which this cell is the last contributor in raster order.
   // Points come out in z, y, x order; the divisor is a power of two, so the
   // mean is an arithmetic shift of the sum, which rounds toward minus infinity.
   task automatic average_cell_into_points(input logic [CELL_W-1:0] raw);
      int             nx, ny, nz, ex, ey, ez, total, n, shift, off, idx;
      int             x, y, z, xc, yc, zc;
      longint         sum, mean;
      grid_point_type pt;
      nx = clamp_size(int'(size_x_reg), MAX_X) - 1;
      ny = clamp_size(int'(size_y_reg), MAX_Y) - 1;
      nz = clamp_size(int'(size_z_reg), LIMIT_Z) - 1;
      ex = (cell_x == nx - 1) ? 1 : 0;
      ey = (cell_y == ny - 1) ? 1 : 0;
      ez = (cell_z == nz - 1) ? 1 : 0;
      total = (ex + 1) * (ey + 1) * (ez + 1);
      n = 0;
      cell_store[store_slot] = raw;
      for (z = cell_z; z <= cell_z + ez; z++) begin
         for (y = cell_y; y <= cell_y + ey; y++) begin
            for (x = cell_x; x <= cell_x + ex; x++) begin
               sum = 0;
               shift = 0;
               // An interior coordinate on an axis means two cells along it.
               if (x >= 1 && x < nx) shift++;
               if (y >= 1 && y < ny) shift++;
               if (z >= 1 && z < nz) shift++;
               for (zc = z - 1; zc <= z; zc++) begin
                  if (zc < 0 || zc >= nz) continue;
                  for (yc = y - 1; yc <= y; yc++) begin
                     if (yc < 0 || yc >= ny) continue;
                     for (xc = x - 1; xc <= x; xc++) begin
                        if (xc < 0 || xc >= nx) continue;
                        // Distance back in the stream from the current cell.
                        off = (cell_z - zc) * nx * ny + (cell_y - yc) * nx + (cell_x - xc);
                        idx = (store_slot + STORE_DEPTH - off) % STORE_DEPTH;
                        sum += cell_store[idx];
                     end
                  end
               end
               n++;
               mean = sum >>> shift;
               pt.value       = mean[CELL_W-1:0];
               pt.x           = x[PX_W-1:0];
               pt.y           = y[PY_W-1:0];
               pt.z           = z[PZ_W-1:0];
               pt.run_last    = (n == total);
               pt.volume_done = (n == total) && ex && ey && ez;
               pending_points.insert(pending_points.size(), pt);
            end
         end
      end
      store_slot = (store_slot + 1) % STORE_DEPTH;
      cell_x++;
      if (cell_x >= nx) begin
         cell_x = 0;
         cell_y++;
         if (cell_y >= ny) begin
            cell_y = 0;
            cell_z++;
            if (cell_z >= nz) cell_z = 0;
         end
      end
   endtask

   // Compares one received point with the oldest one owed. Padding above the
   // z field must be zero as well.
   task automatic check_point(input logic [RSP_DATA_W-1:0] data, input logic last,
                              input logic done);
      grid_point_type got, want;
      logic           pad_bad;
      got.value       = data[CELL_W-1:0];
      got.x           = data[CELL_W +: PX_W];
      got.y           = data[CELL_W + PX_W +: PY_W];
      got.z           = data[CELL_W + PX_W + PY_W +: PZ_W];
      got.run_last    = last;
      got.volume_done = done;
      pad_bad = (data[RSP_DATA_W-1 -: RSP_PAD_W] !== '0);
      if (pending_points.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MISMATCH_REPORTS)
            $display("Unexpected point: value %h x %0d y %0d z %0d last %b done %b",
                     got.value, got.x, got.y, got.z, got.run_last, got.volume_done);
      end else begin
         want = pending_points.pop_front();
         if (got.value !== want.value || got.x !== want.x || got.y !== want.y ||
             got.z !== want.z || got.run_last !== want.run_last ||
             got.volume_done !== want.volume_done || pad_bad) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_REPORTS) begin
               $display("Point mismatch at %0t: expected value %h x %0d y %0d z %0d last %b done %b",
                        $realtime, want.value, want.x, want.y, want.z, want.run_last,
                        want.volume_done);
               $display("   actual value %h x %0d y %0d z %0d last %b done %b pad %h",
                        got.value, got.x, got.y, got.z, got.run_last, got.volume_done,
                        data[RSP_DATA_W-1 -: RSP_PAD_W]);
            end
         end
      end
   endtask

   // Input driver. A transaction completes when tvalid and tready are both high at
   // the edge; the cell is then handed to the predictor. tvalid is written at most
   // once per edge, so a back-to-back cell never sees tvalid dip.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) average_cell_into_points(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (cell_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= cell_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver. Besides random stalls it serves hold-off requests
   // by keeping tready low for a long stretch that it counts itself.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_point(rsp_tdata, rsp_tlast, rsp_tuser);
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            rsp_tready   <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: any transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d points still owed",
                  quiet_cycles, pending_points.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Returns on a falling edge once every queued cell has been taken and every
   // owed point has arrived. Sampling on the falling edge keeps clear of the
   // handshake blocks, which act on the rising edge.
   task automatic wait_for_drain();
      @(negedge clock);
      while (cell_queue.size() != 0 || req_tvalid || pending_points.size() != 0)
         @(negedge clock);
   endtask

   // Drives one register write and updates the shadow registers. Only called
   // while the block is idle, so the early update cannot overtake a cell.
   task automatic write_size(input logic [CSR_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         c2pavg_pkg::CSR_SIZE_X: size_x_reg = val[SX_W-1:0];
         c2pavg_pkg::CSR_SIZE_Y: size_y_reg = val[SY_W-1:0];
         c2pavg_pkg::CSR_SIZE_Z: size_z_reg = val[SZ_W-1:0];
         default: ;
      endcase
      // Any write to a real size register restarts the volume at the origin;
      // the window contents and its write slot carry over.
      if (idx == c2pavg_pkg::CSR_SIZE_X || idx == c2pavg_pkg::CSR_SIZE_Y ||
          idx == c2pavg_pkg::CSR_SIZE_Z) begin
         cell_x = 0;
         cell_y = 0;
         cell_z = 0;
      end
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_sizes(input logic [CSR_DATA_W-1:0] sx,
                                input logic [CSR_DATA_W-1:0] sy,
                                input logic [CSR_DATA_W-1:0] sz);
      write_size(c2pavg_pkg::CSR_SIZE_X, sx);
      write_size(c2pavg_pkg::CSR_SIZE_Y, sy);
      write_size(c2pavg_pkg::CSR_SIZE_Z, sz);
      end_writes();
   endtask

   task automatic queue_random_cells(input int count);
      repeat (count) queue_cell(random_cell());
   endtask

   // Random part of a phase. Most settings are small grids fed as whole volumes
   // (or two back to back, to cross the wrap to a new volume); some stop part way
   // and are cut short by the next register write. A few settings go to the
   // extremes: sizes below two, full-length rows or columns, the deepest z, and
   // register values beyond the limits that must be clamped.
   task automatic run_random_phase(input int target);
      int                    fed, kind, pick, cells, count;
      logic [CSR_DATA_W-1:0] sx, sy, sz;
      fed = 0;
      while (fed < target) begin
         kind = $urandom_range(0, 11);
         case (kind)
            0: begin
               // Sizes of zero or one clamp to two; bits above a register's
               // width are dropped.
               sx = CSR_DATA_W'($urandom_range(0, 1)) | CSR_DATA_W'($urandom_range(0, 31) << 8);
               sy = CSR_DATA_W'($urandom_range(2, 5)) | CSR_DATA_W'($urandom_range(0, 31) << 8);
               sz = CSR_DATA_W'($urandom_range(0, 3));
            end
            1: begin
               sx = CSR_DATA_W'($urandom_range(128, 255));
               sy = 2;
               sz = 2;
            end
            2: begin
               sx = 2;
               sy = CSR_DATA_W'($urandom_range(128, 255));
               sz = 2;
            end
            3: begin
               sx = 2;
               sy = 2;
               sz = CSR_DATA_W'($urandom_range(LIMIT_Z, 8191));
            end
            default: begin
               sx = CSR_DATA_W'($urandom_range(2, 6));
               sy = CSR_DATA_W'($urandom_range(2, 5));
               sz = CSR_DATA_W'($urandom_range(2, 4));
            end
         endcase
         cells = (clamp_size(int'(sx[SX_W-1:0]), MAX_X) - 1) *
                 (clamp_size(int'(sy[SY_W-1:0]), MAX_Y) - 1) *
                 (clamp_size(int'(sz), LIMIT_Z) - 1);
         pick = $urandom_range(0, 9);
         if (kind == 3) count = $urandom_range(20, 60);
         else if (pick >= 8 && cells > 1) count = $urandom_range(1, cells - 1);
         else if (pick >= 6 && cells <= 60) count = 2 * cells;
         else count = cells;
         wait_for_drain();
         program_sizes(sx, sy, sz);
         queue_random_cells(count);
         fed += count;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase one: the sender idles now and then, the receiver mostly.
      send_idle_pct = 33;
      recv_idle_pct = 83;

      // With the reset sizes every cell is a whole volume and sends all eight
      // corners. Extreme values check that a corner, which takes its single cell, comes out unchanged.
      queue_cell(CELL_MAX);
      queue_cell(CELL_MIN);
      queue_cell(32'hFFFF_FFFF);
      queue_cell(32'h0000_0001);

      // A 2x2x2 cell grid puts one point in the middle that averages all eight
      // cells, with the other points taking one, two or four.
      wait_for_drain();
      program_sizes(3, 3, 3);
      queue_cell(CELL_MAX);
      queue_cell(CELL_MIN);
      queue_cell(CELL_MAX);
      queue_cell(CELL_MIN);
      queue_cell(CELL_MIN);
      queue_cell(CELL_MAX);
      queue_cell(32'h0001_0000);
      queue_cell(32'hFFFF_0000);

      // Out-of-range sizes: zero and one clamp up to two, and a z size above
      // the limit clamps down to it.
      wait_for_drain();
      program_sizes(0, 1, 8191);
      queue_random_cells(3);

      // A write to an unmapped index must neither change the sizes nor
      // restart the volume, so the z column just carries on.
      wait_for_drain();
      write_size(CSR_UNMAPPED, CSR_DATA_W'($urandom()));
      end_writes();
      queue_random_cells(2);

      // Two single-register writes, each restarting the volume; six cells on a
      // four-cell grid run past the end into a new volume.
      wait_for_drain();
      write_size(c2pavg_pkg::CSR_SIZE_Z, 2);
      write_size(c2pavg_pkg::CSR_SIZE_X, 5);
      end_writes();
      queue_random_cells(6);

      run_random_phase(PHASE_CELLS);

      // Phase two: the roles swap.
      wait_for_drain();
      send_idle_pct = 83;
      recv_idle_pct = 33;
      run_random_phase(PHASE_CELLS);

      // Phase three: no idling at all. A full-length row is queued and the
      // receiver then holds off for a long stretch while cells keep coming, so
      // the pipeline backs up into req_tready.
      wait_for_drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_sizes(CSR_DATA_W'(MAX_X), 2, 2);
      queue_random_cells(MAX_X - 1);
      hold_requests = hold_requests + 1;
      run_random_phase(PHASE_CELLS);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_points.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
rtl/c2pavg_pkg.sv
rtl/cell_to_point_average_3d.sv
tb/tb.sv
